// ===== sv/qse_pkg.sv =====
package qse_pkg;

  // Capacity of the element store; the range stack has the same depth.
  localparam int unsigned MaxItems   = 64;
  localparam int unsigned StackDepth = MaxItems;
  localparam int unsigned IdxW       = $clog2(MaxItems);
  localparam int unsigned CntW       = $clog2(MaxItems + 1);
  // Scan indices run one past either end of a range, so they carry a sign and a spare bit.
  localparam int unsigned PtrW       = IdxW + 2;
  localparam int unsigned ValW       = 32;
  localparam int unsigned RangeW     = 2 * IdxW;

  typedef logic signed [PtrW-1:0] ptr_t;
  typedef logic signed [ValW-1:0] val_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               last_res;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    val_t            wdata;
    logic [IdxW-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic              we;
    logic [IdxW-1:0]   waddr;
    logic [RangeW-1:0] wdata;
    logic [IdxW-1:0]   raddr;
  } stack_req_t;

  typedef enum logic [3:0] {
    StLoad,
    StPop,
    StPopWait,
    StRange,
    StPivWait,
    StOuter,
    StScanI,
    StScanJ,
    StSwapI,
    StSwapJ,
    StPartEnd,
    StEmitRd,
    StEmitWait,
    StEmitHold
  } state_e;

endpackage

// ===== sv/quicksort_engine_top.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i  (qse_pkg::in_t)
// out       output     out_valid_o / out_ready_i out_data_o (qse_pkg::out_t)
//
// Loading takes one element per cycle while the block is in its load phase.
// After the element marked last, in_ready_o stays low while the sort runs over the
// element memory: a scan steps past one element per cycle and a swap writes both
// elements back, so the total depends on the data. Results then leave one at a
// time through the registered memory read, the next one read once the current
// one is taken. Reset needs no clearing pass; output stalls simply hold the result.
module quicksort_engine_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qse_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qse_pkg::out_t out_data_o
);

  qse_pkg::store_req_t           store_req;
  qse_pkg::stack_req_t           stack_req;
  qse_pkg::val_t                 store_rdata;
  logic [qse_pkg::RangeW-1:0]    stack_rdata;

  qse_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .store_req_o   (store_req),
    .store_rdata_i (store_rdata),
    .stack_req_o   (stack_req),
    .stack_rdata_i (stack_rdata)
  );

  qse_ram #(
    .Width (qse_pkg::ValW),
    .Depth (qse_pkg::MaxItems)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_req.we),
    .waddr_i (store_req.waddr),
    .wdata_i (store_req.wdata),
    .raddr_i (store_req.raddr),
    .rdata_o (store_rdata)
  );

  qse_ram #(
    .Width (qse_pkg::RangeW),
    .Depth (qse_pkg::StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stack_req.we),
    .waddr_i (stack_req.waddr),
    .wdata_i (stack_req.wdata),
    .raddr_i (stack_req.raddr),
    .rdata_o (stack_rdata)
  );

endmodule

// ===== sv/qse_ram.sv =====
module qse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/qse_core.sv =====
module qse_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  qse_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output qse_pkg::out_t               out_data_o,
  output qse_pkg::store_req_t         store_req_o,
  input  qse_pkg::val_t               store_rdata_i,
  output qse_pkg::stack_req_t         stack_req_o,
  input  logic [qse_pkg::RangeW-1:0]  stack_rdata_i
);

  qse_pkg::state_e state_q, state_d;

  logic [qse_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [qse_pkg::CntW-1:0] sp_q, sp_d;
  logic                     drop_q, drop_d;
  logic [qse_pkg::IdxW-1:0] k_q, k_d;

  qse_pkg::ptr_t lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  qse_pkg::val_t pivot_q, pivot_d, ai_q, ai_d;
  qse_pkg::out_t out_q, out_d;

  logic                     full;
  logic [qse_pkg::CntW-1:0] n_after;
  qse_pkg::ptr_t            mid, i_inc, j_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qse_pkg::StLoad;
      cnt_q   <= '0;
      sp_q    <= '0;
      drop_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sp_q    <= sp_d;
      drop_q  <= drop_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    j_q     <= j_d;
    pivot_q <= pivot_d;
    ai_q    <= ai_d;
    out_q   <= out_d;
  end

  assign full    = (cnt_q == qse_pkg::CntW'(qse_pkg::MaxItems));
  assign n_after = full ? cnt_q : cnt_q + qse_pkg::CntW'(1);
  assign mid     = (lo_q + hi_q) >>> 1;
  assign i_inc   = i_q + qse_pkg::ptr_t'(1);
  assign j_dec   = j_q - qse_pkg::ptr_t'(1);

  assign in_ready_o  = (state_q == qse_pkg::StLoad);
  assign out_valid_o = (state_q == qse_pkg::StEmitHold);
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sp_d    = sp_q;
    drop_d  = drop_q;
    k_d     = k_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    pivot_d = pivot_q;
    ai_d    = ai_q;
    out_d   = out_q;

    store_req_o       = '0;
    store_req_o.raddr = i_q[qse_pkg::IdxW-1:0];
    stack_req_o       = '0;
    stack_req_o.raddr = sp_q[qse_pkg::IdxW-1:0];

    unique case (state_q)
      qse_pkg::StLoad: begin
        if (in_valid_i) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            store_req_o.we    = 1'b1;
            store_req_o.waddr = cnt_q[qse_pkg::IdxW-1:0];
            store_req_o.wdata = in_data_i.value;
            cnt_d             = n_after;
          end
          if (in_data_i.last) begin
            k_d = '0;
            if (n_after < qse_pkg::CntW'(2)) begin
              state_d = qse_pkg::StEmitRd;
            end else begin
              // The whole list is the first range.
              stack_req_o.we    = 1'b1;
              stack_req_o.waddr = '0;
              stack_req_o.wdata = {qse_pkg::IdxW'(0),
                                   qse_pkg::IdxW'(n_after - qse_pkg::CntW'(1))};
              sp_d              = qse_pkg::CntW'(1);
              state_d           = qse_pkg::StPop;
            end
          end
        end
      end

      qse_pkg::StPop: begin
        if (sp_q == '0) begin
          state_d = qse_pkg::StEmitRd;
        end else begin
          stack_req_o.raddr = qse_pkg::IdxW'(sp_q - qse_pkg::CntW'(1));
          sp_d              = sp_q - qse_pkg::CntW'(1);
          state_d           = qse_pkg::StPopWait;
        end
      end

      qse_pkg::StPopWait: begin
        lo_d    = qse_pkg::ptr_t'({2'b00, stack_rdata_i[qse_pkg::RangeW-1:qse_pkg::IdxW]});
        hi_d    = qse_pkg::ptr_t'({2'b00, stack_rdata_i[qse_pkg::IdxW-1:0]});
        state_d = qse_pkg::StRange;
      end

      qse_pkg::StRange: begin
        if (lo_q < hi_q) begin
          store_req_o.raddr = mid[qse_pkg::IdxW-1:0];
          state_d           = qse_pkg::StPivWait;
        end else begin
          state_d = qse_pkg::StPop;
        end
      end

      qse_pkg::StPivWait: begin
        pivot_d = store_rdata_i;
        i_d     = lo_q;
        j_d     = hi_q;
        state_d = qse_pkg::StOuter;
      end

      qse_pkg::StOuter: begin
        if (i_q <= j_q) begin
          store_req_o.raddr = i_q[qse_pkg::IdxW-1:0];
          state_d           = qse_pkg::StScanI;
        end else begin
          state_d = qse_pkg::StPartEnd;
        end
      end

      // Each scan step checks the element fetched in the cycle before
      // and fetches the next one in case the scan goes on.
      qse_pkg::StScanI: begin
        if (i_q < hi_q && store_rdata_i < pivot_q) begin
          i_d               = i_inc;
          store_req_o.raddr = i_inc[qse_pkg::IdxW-1:0];
        end else begin
          ai_d              = store_rdata_i;
          store_req_o.raddr = j_q[qse_pkg::IdxW-1:0];
          state_d           = qse_pkg::StScanJ;
        end
      end

      qse_pkg::StScanJ: begin
        if (j_q > lo_q && pivot_q < store_rdata_i) begin
          j_d               = j_dec;
          store_req_o.raddr = j_dec[qse_pkg::IdxW-1:0];
        end else begin
          // The element at j is kept in the value_res field of the output register.
          pivot_d = pivot_q;
          out_d.value_res = store_rdata_i;
          state_d         = (i_q <= j_q) ? qse_pkg::StSwapI : qse_pkg::StOuter;
        end
      end

      qse_pkg::StSwapI: begin
        store_req_o.we    = 1'b1;
        store_req_o.waddr = i_q[qse_pkg::IdxW-1:0];
        store_req_o.wdata = out_q.value_res;
        state_d           = qse_pkg::StSwapJ;
      end

      qse_pkg::StSwapJ: begin
        store_req_o.we    = 1'b1;
        store_req_o.waddr = j_q[qse_pkg::IdxW-1:0];
        store_req_o.wdata = ai_q;
        i_d               = i_inc;
        j_d               = j_dec;
        state_d           = qse_pkg::StOuter;
      end

      // Push the larger part and carry on with the smaller one, which
      // bounds the stack depth by the log of the list length.
      qse_pkg::StPartEnd: begin
        if ((j_q - lo_q) < (hi_q - i_q)) begin
          if (i_q < hi_q && sp_q < qse_pkg::CntW'(qse_pkg::StackDepth)) begin
            stack_req_o.we    = 1'b1;
            stack_req_o.waddr = sp_q[qse_pkg::IdxW-1:0];
            stack_req_o.wdata = {i_q[qse_pkg::IdxW-1:0], hi_q[qse_pkg::IdxW-1:0]};
            sp_d              = sp_q + qse_pkg::CntW'(1);
          end
          hi_d = j_q;
        end else begin
          if (lo_q < j_q && sp_q < qse_pkg::CntW'(qse_pkg::StackDepth)) begin
            stack_req_o.we    = 1'b1;
            stack_req_o.waddr = sp_q[qse_pkg::IdxW-1:0];
            stack_req_o.wdata = {lo_q[qse_pkg::IdxW-1:0], j_q[qse_pkg::IdxW-1:0]};
            sp_d              = sp_q + qse_pkg::CntW'(1);
          end
          lo_d = i_q;
        end
        state_d = qse_pkg::StRange;
      end

      qse_pkg::StEmitRd: begin
        store_req_o.raddr = k_q;
        state_d           = qse_pkg::StEmitWait;
      end

      qse_pkg::StEmitWait: begin
        out_d.value_res = store_rdata_i;
        out_d.last_res  = (qse_pkg::CntW'(k_q) + qse_pkg::CntW'(1) == cnt_q);
        out_d.overflow  = drop_q;
        state_d         = qse_pkg::StEmitHold;
      end

      qse_pkg::StEmitHold: begin
        if (out_ready_i) begin
          if (out_q.last_res) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            sp_d    = '0;
            state_d = qse_pkg::StLoad;
          end else begin
            k_d               = k_q + qse_pkg::IdxW'(1);
            store_req_o.raddr = k_q + qse_pkg::IdxW'(1);
            state_d           = qse_pkg::StEmitWait;
          end
        end
      end

      default: begin
        state_d = qse_pkg::StLoad;
      end
    endcase
  end

endmodule

// ===== sv/qse_checker.sv =====
module qse_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input qse_pkg::out_t out_data_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Loading and emitting never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is shown");

  // After the final result the block goes back to loading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_res |=> in_ready_o && !out_valid_o)
    else $error("block did not return to loading after the final result");

  // Between results of one list no input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_res |=> !in_ready_o)
    else $error("input taken in the middle of a result list");

  // The overflow flag is the same on consecutive results of a list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_res |=> ##1
      out_data_o.overflow == $past(out_data_o.overflow, 2))
    else $error("overflow flag changed within a list");

endmodule

bind quicksort_engine_top qse_checker u_qse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam qse_pkg::val_t VMin = 32'sh8000_0000;
  localparam qse_pkg::val_t VMax = 32'sh7fff_ffff;
  localparam int   HoldCycles = 400;
  localparam int   TargetItems = 130;

  typedef struct {
    qse_pkg::in_t  item;
    bit            typed;
    qse_pkg::out_t want;
  } row_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  qse_pkg::in_t  in_data_i   = '0;
  logic          out_ready_i = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  qse_pkg::out_t out_data_o;

  // Receiver controls, driven by the stimulus process.
  logic calm     = 1'b0;
  logic hold_req = 1'b0;

  qse_pkg::out_t sorted_due [$];
  qse_pkg::val_t pending [qse_pkg::MaxItems];
  int unsigned   held;
  bit            dropped;
  row_t          plan [$];

  int mismatches   = 0;
  int items_sent   = 0;
  int lists_done   = 0;
  int results_seen = 0;
  int overflow_lists = 0;

  quicksort_engine_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Collects one element; on the element marked last, sorts the list and queues its results.
  function automatic void absorb_element(input qse_pkg::in_t it, input bit typed,
                                         input qse_pkg::out_t want);
    qse_pkg::val_t key;
    int            k;
    int            m;
    qse_pkg::out_t res;
    if (held < qse_pkg::MaxItems) begin
      pending[held] = it.value;
      held++;
    end else begin
      dropped = 1'b1;
    end
    if (!it.last) return;
    for (k = 1; k < held; k++) begin
      key = pending[k];
      m = k - 1;
      while (m >= 0 && pending[m] > key) begin
        pending[m+1] = pending[m];
        m--;
      end
      pending[m+1] = key;
    end
    if (typed) begin
      sorted_due.push_back(want);
    end else begin
      for (k = 0; k < held; k++) begin
        res.value_res = pending[k];
        res.last_res  = (k == held - 1);
        res.overflow  = dropped;
        sorted_due.push_back(res);
      end
    end
    if (dropped) overflow_lists++;
    lists_done++;
    held    = 0;
    dropped = 1'b0;
  endfunction

  task automatic offer(input qse_pkg::in_t it, input bit typed, input qse_pkg::out_t want);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    absorb_element(it, typed, want);
  endtask

  function automatic void add_row(input qse_pkg::val_t v, input bit last, input bit typed);
    row_t r;
    r.item.value     = v;
    r.item.last      = last;
    r.typed          = typed;
    r.want.value_res = v;
    r.want.last_res  = 1'b1;
    r.want.overflow  = 1'b0;
    plan.push_back(r);
  endfunction

  // Mix of extremes, a narrow band that yields many equal keys, and full-range values.
  function automatic qse_pkg::val_t pick_value();
    case ($urandom_range(7))
      0:       return VMin;
      1:       return VMax;
      2, 3:    return qse_pkg::val_t'($urandom_range(8)) - 4;
      default: return qse_pkg::val_t'($urandom);
    endcase
  endfunction

  task automatic send_random_list(input int len);
    qse_pkg::in_t it;
    int           e;
    for (e = 0; e < len; e++) begin
      it.value = pick_value();
      it.last  = (e == len - 1);
      offer(it, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, and calm stretches.
  int hold_left  = 0;
  bit hold_taken = 1'b0;
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    qse_pkg::out_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected result value_res %0d last_res %0b overflow %0b",
                 $time, out_data_o.value_res, out_data_o.last_res, out_data_o.overflow);
        mismatches++;
      end else begin
        exp_res = sorted_due.pop_front();
        if (out_data_o.value_res !== exp_res.value_res) begin
          $display("%0t: value_res expected %0d actual %0d",
                   $time, exp_res.value_res, out_data_o.value_res);
          mismatches++;
        end
        if (out_data_o.last_res !== exp_res.last_res) begin
          $display("%0t: last_res expected %0b actual %0b",
                   $time, exp_res.last_res, out_data_o.last_res);
          mismatches++;
        end
        if (out_data_o.overflow !== exp_res.overflow) begin
          $display("%0t: overflow expected %0b actual %0b",
                   $time, exp_res.overflow, out_data_o.overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int li;
    int len;
    int r;
    held    = 0;
    dropped = 1'b0;

    // Single-element lists come straight back unchanged; a six-element list follows.
    add_row(VMin, 1'b1, 1'b1);
    add_row(VMax, 1'b1, 1'b1);
    add_row(32'sd0, 1'b1, 1'b1);
    add_row(-32'sd1, 1'b1, 1'b1);
    add_row(32'sd5, 1'b0, 1'b0);
    add_row(-32'sd3, 1'b0, 1'b0);
    add_row(VMax, 1'b0, 1'b0);
    add_row(VMin, 1'b0, 1'b0);
    add_row(32'sd0, 1'b0, 1'b0);
    add_row(-32'sd1, 1'b1, 1'b0);
    // All keys equal the pivot; two short mixed lists follow.
    add_row(32'sd7, 1'b0, 1'b0);
    add_row(32'sd7, 1'b0, 1'b0);
    add_row(32'sd7, 1'b0, 1'b0);
    add_row(32'sd7, 1'b1, 1'b0);
    add_row(32'sd2, 1'b0, 1'b0);
    add_row(32'sd1, 1'b1, 1'b0);
    add_row(-32'sd1, 1'b0, 1'b0);
    add_row(32'sh5555_5555, 1'b0, 1'b0);
    add_row(32'shAAAA_AAAA, 1'b1, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < plan.size(); r++) offer(plan[r].item, plan[r].typed, plan[r].want);

    // The last planned list meets a long output hold-off, so the first random list stalls at the input.
    hold_req   <= 1'b1;
    li         = 0;
    while (items_sent < TargetItems) begin
      calm <= (li >= 1 && li <= 3);
      if (li == 1) len = qse_pkg::MaxItems / 2;
      else if (li == 4) len = qse_pkg::MaxItems + 2;   // the store fills and the marked element is dropped
      else if ($urandom_range(5) == 0) len = 1;
      else len = $urandom_range(10, 2);
      send_random_list(len);
      li++;
    end
    in_valid_i <= 1'b0;
    calm       <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Sent %0d elements in %0d lists (%0d with dropped elements); checked %0d results.",
             items_sent, lists_done, overflow_lists, results_seen);
    $display("Lists ranged from one element to past full capacity, with extremes and repeats.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/qse_pkg.sv
sv/qse_ram.sv
sv/qse_core.sv
sv/quicksort_engine_top.sv
sv/qse_checker.sv
tb/sv/tb.sv
